[hdl/rsqf_pkg.sv]
// shared types, constants and arithmetic helpers of the resampled quadrature filter
package rsqf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int STATE_FRAC  = 30 - SAMPLE_BITS;
    localparam int ACC_W       = 67;
    localparam int RND_W       = ACC_W - 30;
    localparam int SUM_W       = RND_W + 1;
    localparam int DVD_W       = 64;
    localparam int DVS_W       = 32;

    localparam logic [2:0] REG_GRID_STEP     = 3'd0;
    localparam logic [2:0] REG_COEF_ALPHA_B0 = 3'd1;
    localparam logic [2:0] REG_COEF_A1       = 3'd2;
    localparam logic [2:0] REG_COEF_A2       = 3'd3;
    localparam logic [2:0] REG_COEF_BETA_B0  = 3'd4;

    localparam logic [23:0] GRID_STEP_RST = 24'd1000;
    localparam logic [15:0] CONF_ONE      = 16'd32768;

    typedef enum logic [2:0] {
        JOB_Q, JOB_U, JOB_A1, JOB_A2, JOB_AB, JOB_B1, JOB_B2, JOB_BB
    } t_job;

    typedef enum logic [1:0] {
        DSEL_N, DSEL_CONF, DSEL_Q
    } t_dsel;

    typedef struct packed {
        logic [23:0] grid_step;
        logic [31:0] coef_alpha_b0;
        logic [31:0] coef_a1;
        logic [31:0] coef_a2;
        logic [31:0] coef_beta_b0;
    } t_cfg;

    typedef struct packed {
        logic       load_in;
        logic       store_first;
        logic       advance;
        logic       div_start;
        t_dsel      div_sel;
        logic       latch_n;
        logic       set_conf_full;
        logic       latch_conf;
        logic       mul_en;
        t_job       job;
        logic [1:0] phase;
        logic       fin_job;
        logic       latch_ip;
        logic       push;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic drop;
        logic empty;
        logic conf_full;
        logic div_busy;
        logic div_done;
        logic last_pt;
        logic out_full;
    } t_dp_stat;

    function automatic logic [31:0] sat32(input logic [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] v;
        logic [31:0]             r;
        v = $signed(x);
        if (v > $signed({{(SUM_W-31){1'b0}}, {31{1'b1}}})) begin
            r = 32'h7FFF_FFFF;
        end else if (v < $signed({{(SUM_W-31){1'b1}}, {31{1'b0}}})) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // round half up to whole samples, then saturate
    function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [RND_W-1:0] x);
        logic [RND_W-1:0]                    t;
        logic signed [RND_W-STATE_FRAC-1:0]  s;
        logic [SAMPLE_BITS-1:0]              r;
        t = x + {{(RND_W-STATE_FRAC){1'b0}}, 1'b1, {(STATE_FRAC-1){1'b0}}};
        s = $signed(t[RND_W-1:STATE_FRAC]);
        if (s > $signed({{(RND_W-STATE_FRAC-SAMPLE_BITS+1){1'b0}},
                         {(SAMPLE_BITS-1){1'b1}}})) begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (s < $signed({{(RND_W-STATE_FRAC-SAMPLE_BITS+1){1'b1}},
                                  {(SAMPLE_BITS-1){1'b0}}})) begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            r = t[STATE_FRAC+SAMPLE_BITS-1:STATE_FRAC];
        end
        return r;
    endfunction

endpackage

[hdl/resampled_sogi_quadrature_filter_unit.sv]
// Resampled SOGI quadrature filter: timestamped samples in, resampled filter outputs out.
// The slave stream takes one request per sample: tdata holds the timestamp and the
// sample, tuser restarts the grid at that timestamp. For every grid point between the
// previous and the current timestamp the block interpolates a sample, blends it by its
// confidence with the last in-phase output and runs both biquads. Each grid point gives
// one request on the master stream; tlast marks the last point of a sample, tuser
// flags a run cut short after MAX_RUN points with the grid resynced.
// A sample that gives no grid point ends after the check. One that gives points runs a
// check, a point count divide, a confidence step and a closing step, plus a divide when the
// confidence must be divided; for every grid point a 64-step radix-2 divider does the
// interpolation, and a shared 33x18 multiplier runs eight jobs.
// The slave side is ready only between samples. Results sit in a one-deep output
// register; a stalled receiver holds the engine before its next push, and the next
// sample is taken while the last result still waits.
// Reset clears the filter and grid state, marks no previous sample and loads the
// registers with their defaults (grid_step 1000, coefficients zero). The APB port is
// to be written only between samples; the user must keep to this, the block does not enforce it.
module resampled_sogi_quadrature_filter_unit #(
    parameter int MAX_RUN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] timestamp, [47:32] sample_value
    input  logic        s_tuser,   // [0] restart_grid
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] alpha_out, [31:16] beta_out,
                                   // [47:32] confidence, [79:48] grid_time
    output logic        m_tlast,
    output logic        m_tuser,   // [0] gap_overflow
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0] r_grid_step;
    logic [31:0] r_coef_alpha_b0, r_coef_a1, r_coef_a2, r_coef_beta_b0;

    rsqf_pkg::t_cfg     cfg;
    rsqf_pkg::t_dp_cmd  dp_cmd;
    rsqf_pkg::t_dp_stat dp_stat;
    logic [15:0] out_alpha, out_beta, out_conf;
    logic [31:0] out_grid;
    logic        out_ovf, out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step     <= rsqf_pkg::GRID_STEP_RST;
            r_coef_alpha_b0 <= '0;
            r_coef_a1       <= '0;
            r_coef_a2       <= '0;
            r_coef_beta_b0  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                rsqf_pkg::REG_GRID_STEP:     r_grid_step     <= pwdata[23:0];
                rsqf_pkg::REG_COEF_ALPHA_B0: r_coef_alpha_b0 <= pwdata;
                rsqf_pkg::REG_COEF_A1:       r_coef_a1       <= pwdata;
                rsqf_pkg::REG_COEF_A2:       r_coef_a2       <= pwdata;
                rsqf_pkg::REG_COEF_BETA_B0:  r_coef_beta_b0  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rsqf_pkg::REG_GRID_STEP:     prdata = {8'b0, r_grid_step};
            rsqf_pkg::REG_COEF_ALPHA_B0: prdata = r_coef_alpha_b0;
            rsqf_pkg::REG_COEF_A1:       prdata = r_coef_a1;
            rsqf_pkg::REG_COEF_A2:       prdata = r_coef_a2;
            rsqf_pkg::REG_COEF_BETA_B0:  prdata = r_coef_beta_b0;
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign cfg.grid_step     = r_grid_step;
    assign cfg.coef_alpha_b0 = r_coef_alpha_b0;
    assign cfg.coef_a1       = r_coef_a1;
    assign cfg.coef_a2       = r_coef_a2;
    assign cfg.coef_beta_b0  = r_coef_beta_b0;

    rsqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    rsqf_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_ts        (s_tdata[31:0]),
        .i_val       (s_tdata[47:32]),
        .i_restart   (s_tuser),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_alpha     (out_alpha),
        .o_beta      (out_beta),
        .o_conf      (out_conf),
        .o_grid      (out_grid),
        .o_ovf       (out_ovf),
        .o_last      (out_last)
    );

    assign m_tdata = {out_grid, out_conf, out_beta, out_alpha};
    assign m_tlast = out_last;
    assign m_tuser = out_ovf;

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.push |-> !dp_stat.out_full)
        else $error("result pushed into a full output register");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.div_start |-> !dp_stat.div_busy)
        else $error("divider started while busy");

    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[47:32] <= 16'd32768))
        else $error("confidence above one");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample taken before the first was handled");
`endif

endmodule

[hdl/rsqf_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module rsqf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rsqf_pkg::DVD_W-1:0]    i_dividend,
    input  logic [rsqf_pkg::DVS_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [rsqf_pkg::DVD_W-1:0]    o_quot
);

    localparam int CW = $clog2(rsqf_pkg::DVD_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [rsqf_pkg::DVS_W-1:0]    r_rem;
    logic [rsqf_pkg::DVS_W-1:0]    r_dvs;
    logic [rsqf_pkg::DVD_W-1:0]    r_quo;
    logic [rsqf_pkg::DVS_W:0]      rem_sh;
    logic [rsqf_pkg::DVS_W:0]      rem_sub;
    logic                          fits;

    assign rem_sh  = {r_rem, r_quo[rsqf_pkg::DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {CW{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[rsqf_pkg::DVS_W-1:0] : rem_sh[rsqf_pkg::DVS_W-1:0];
            r_quo <= {r_quo[rsqf_pkg::DVD_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[hdl/rsqf_dp.sv]
// datapath: sample state, grid tracking, shared multiplier, biquads, result register
module rsqf_dp #(
    parameter int MAX_RUN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsqf_pkg::t_cfg       i_cfg,
    input  rsqf_pkg::t_dp_cmd    i_cmd,
    output rsqf_pkg::t_dp_stat   o_stat,
    input  logic [31:0]          i_ts,
    input  logic [15:0]          i_val,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [15:0]          o_alpha,
    output logic [15:0]          o_beta,
    output logic [15:0]          o_conf,
    output logic [31:0]          o_grid,
    output logic                 o_ovf,
    output logic                 o_last
);

    localparam int NW    = $clog2(MAX_RUN + 1);
    localparam int ACC_W = rsqf_pkg::ACC_W;
    localparam int RND_W = rsqf_pkg::RND_W;
    localparam int SUM_W = rsqf_pkg::SUM_W;

    // request and model state
    logic [31:0] r_ts;
    logic [15:0] r_val;
    logic        r_rst;
    logic [31:0] r_prev_time;
    logic [15:0] r_prev_val;
    logic        r_have_prev;
    logic [31:0] r_next_grid;
    logic [31:0] r_ad1, r_ad2, r_bd1, r_bd2;
    logic [15:0] r_fb;

    // run state
    logic [31:0]      r_dtarg;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_k;
    logic             r_ovf;
    logic [15:0]      r_conf;
    logic [32:0]      r_ip;
    logic [32:0]      r_u;
    logic [SUM_W-1:0] r_sum;
    logic [31:0]      r_in;
    logic [RND_W-1:0] r_va;

    // multiplier pipeline
    logic [50:0]      r_prod;
    logic             r_pv;
    logic             r_pfirst;
    logic             r_pshift;
    logic [ACC_W-1:0] r_acc;

    // result register
    logic        r_ov;
    logic [15:0] r_o_alpha, r_o_beta, r_o_conf;
    logic [31:0] r_o_grid;
    logic        r_o_ovf, r_o_last;

    logic [23:0] step;
    logic [25:0] step3;
    logic [31:0] gap, off;
    logic [16:0] diff, absd;
    logic        neg;
    logic [30:0] mag;
    logic [63:0] dvd;
    logic [31:0] dvs;
    logic        div_busy, div_done;
    logic [63:0] quo;
    logic [33:0] s34;
    logic [31:0] coef;
    logic [32:0] mul_a;
    logic [17:0] mul_b;
    logic        mul_shift;
    logic signed [50:0] prod;
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] acc_r;
    logic [RND_W-1:0] rnd;
    logic [ACC_W-1:0] acc_u;
    logic [SUM_W-1:0] sum_next;
    logic [32:0]      pv33, fb33, ip_next;
    logic [15:0]      va_s;

    assign step  = (i_cfg.grid_step == 24'd0) ? 24'd1 : i_cfg.grid_step;
    assign step3 = {2'b0, step} + {1'b0, step, 1'b0};
    assign gap   = r_ts - r_prev_time;
    assign off   = r_next_grid - r_prev_time;
    assign diff  = {r_val[15], r_val} - {r_prev_val[15], r_prev_val};
    assign neg   = diff[16];
    assign absd  = neg ? (17'd0 - diff) : diff;
    assign mag   = {absd[16:0], {rsqf_pkg::STATE_FRAC{1'b0}}};

    always_comb begin
        case (i_cmd.div_sel)
            rsqf_pkg::DSEL_CONF: begin
                dvd = {23'b0, step3, 15'b0} + {32'b0, gap};
                dvs = {gap[30:0], 1'b0};
            end
            rsqf_pkg::DSEL_Q: begin
                dvd = r_acc[63:0] + {33'b0, gap[31:1]};
                dvs = gap;
            end
            default: begin
                dvd = {32'b0, gap - 32'd1 - off};
                dvs = {8'b0, step};
            end
        endcase
    end

    rsqf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quo)
    );

    // filter operand of the coefficient products
    always_comb begin
        case (i_cmd.job)
            rsqf_pkg::JOB_A1: s34 = {{2{r_ad1[31]}}, r_ad1};
            rsqf_pkg::JOB_A2: s34 = {{2{r_ad2[31]}}, r_ad2};
            rsqf_pkg::JOB_AB: s34 = {{2{r_in[31]}}, r_in} - {{2{r_ad2[31]}}, r_ad2};
            rsqf_pkg::JOB_B1: s34 = {{2{r_bd1[31]}}, r_bd1};
            rsqf_pkg::JOB_B2: s34 = {{2{r_bd2[31]}}, r_bd2};
            rsqf_pkg::JOB_BB: s34 = {{2{r_in[31]}}, r_in} + {r_bd1[31], r_bd1, 1'b0}
                                    + {{2{r_bd2[31]}}, r_bd2};
            default:          s34 = '0;
        endcase
        case (i_cmd.job)
            rsqf_pkg::JOB_A1, rsqf_pkg::JOB_B1: coef = i_cfg.coef_a1;
            rsqf_pkg::JOB_A2, rsqf_pkg::JOB_B2: coef = i_cfg.coef_a2;
            rsqf_pkg::JOB_AB:                   coef = i_cfg.coef_alpha_b0;
            rsqf_pkg::JOB_BB:                   coef = i_cfg.coef_beta_b0;
            default:                            coef = '0;
        endcase
    end

    assign fb33 = {{3{r_fb[15]}}, r_fb, {rsqf_pkg::STATE_FRAC{1'b0}}};

    always_comb begin
        case (i_cmd.job)
            rsqf_pkg::JOB_Q: begin
                mul_a     = {2'b0, mag};
                mul_b     = i_cmd.phase[0] ? {3'b0, r_dtarg[30:16]} : {2'b0, r_dtarg[15:0]};
                mul_shift = i_cmd.phase[0];
            end
            rsqf_pkg::JOB_U: begin
                mul_a     = i_cmd.phase[0] ? fb33 : r_ip;
                mul_b     = i_cmd.phase[0] ? {2'b0, rsqf_pkg::CONF_ONE - r_conf}
                                           : {2'b0, r_conf};
                mul_shift = 1'b0;
            end
            default: begin
                mul_a     = {coef[31], coef};
                mul_b     = i_cmd.phase[0] ? s34[33:16] : {2'b0, s34[15:0]};
                mul_shift = i_cmd.phase[0];
            end
        endcase
    end

    assign prod  = $signed(mul_a) * $signed(mul_b);
    assign term  = r_pshift ? {r_prod, 16'b0} : {{16{r_prod[50]}}, r_prod};
    assign acc_r = r_acc + {{(ACC_W-30){1'b0}}, 1'b1, 29'b0};
    assign rnd   = acc_r[ACC_W-1:30];
    assign acc_u = r_acc + {{(ACC_W-15){1'b0}}, 1'b1, 14'b0};
    assign sum_next = r_sum - {rnd[RND_W-1], rnd};
    assign pv33  = {{3{r_prev_val[15]}}, r_prev_val, {rsqf_pkg::STATE_FRAC{1'b0}}};
    assign ip_next = neg ? (pv33 - {1'b0, quo[31:0]}) : (pv33 + {1'b0, quo[31:0]});
    assign va_s  = rsqf_pkg::to_sample(r_va);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod   <= prod;
            r_pfirst <= (i_cmd.phase == 2'd0);
            r_pshift <= mul_shift;
        end
        if (r_pv) begin
            r_acc <= r_pfirst ? term : (r_acc + term);
        end
    end

    // model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_prev_val  <= '0;
            r_have_prev <= 1'b0;
            r_next_grid <= '0;
            r_ad1       <= '0;
            r_ad2       <= '0;
            r_bd1       <= '0;
            r_bd2       <= '0;
            r_fb        <= '0;
        end else begin
            if (i_cmd.store_first) begin
                r_prev_time <= r_ts;
                r_prev_val  <= r_val;
                r_have_prev <= 1'b1;
                r_next_grid <= r_ts;
            end
            if (i_cmd.advance) begin
                r_prev_time <= r_ts;
                r_prev_val  <= r_val;
            end
            if (i_cmd.finish) begin
                r_prev_time <= r_ts;
                r_prev_val  <= r_val;
                r_next_grid <= r_ovf ? r_ts : (r_prev_time + r_dtarg);
            end
            if (i_cmd.fin_job && i_cmd.job == rsqf_pkg::JOB_AB) begin
                r_ad2 <= r_ad1;
                r_ad1 <= r_in;
            end
            if (i_cmd.fin_job && i_cmd.job == rsqf_pkg::JOB_BB) begin
                r_bd2 <= r_bd1;
                r_bd1 <= r_in;
                r_fb  <= va_s;
            end
        end
    end

    // request and run registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ts  <= i_ts;
            r_val <= i_val;
            r_rst <= i_restart;
        end
        if (i_cmd.latch_n) begin
            r_dtarg <= off;
            r_k     <= '0;
            if (quo >= 64'(MAX_RUN)) begin
                r_ovf <= 1'b1;
                r_n   <= NW'(MAX_RUN);
            end else begin
                r_ovf <= 1'b0;
                r_n   <= quo[NW-1:0] + NW'(1);
            end
        end
        if (i_cmd.set_conf_full) begin
            r_conf <= rsqf_pkg::CONF_ONE;
        end
        if (i_cmd.latch_conf) begin
            r_conf <= quo[15:0];
        end
        if (i_cmd.latch_ip) begin
            r_ip <= ip_next;
        end
        if (i_cmd.push) begin
            r_dtarg <= r_dtarg + {8'b0, step};
            r_k     <= r_k + NW'(1);
        end
        if (i_cmd.fin_job) begin
            case (i_cmd.job)
                rsqf_pkg::JOB_U: begin
                    r_u   <= acc_u[47:15];
                    r_sum <= {{(SUM_W-33){acc_u[47]}}, acc_u[47:15]};
                end
                rsqf_pkg::JOB_A1, rsqf_pkg::JOB_B1: begin
                    r_sum <= sum_next;
                end
                rsqf_pkg::JOB_A2, rsqf_pkg::JOB_B2: begin
                    r_in <= rsqf_pkg::sat32(sum_next);
                end
                rsqf_pkg::JOB_AB: begin
                    r_va  <= rnd;
                    r_sum <= {{(SUM_W-33){r_u[32]}}, r_u};
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_alpha <= va_s;
            r_o_beta  <= rsqf_pkg::to_sample(rnd);
            r_o_conf  <= r_conf;
            r_o_grid  <= r_prev_time + r_dtarg;
            r_o_ovf   <= r_ovf;
            r_o_last  <= (r_k == r_n - NW'(1));
        end
    end

    always_comb begin
        o_stat.first     = r_rst | ~r_have_prev;
        o_stat.drop      = (gap == 32'd0) | gap[31];
        o_stat.empty     = ~(off < gap);
        o_stat.conf_full = {gap, 1'b0} <= {7'b0, step3};
        o_stat.div_busy  = div_busy;
        o_stat.div_done  = div_done;
        o_stat.last_pt   = (r_k == r_n - NW'(1));
        o_stat.out_full  = r_ov & ~i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_alpha     = r_o_alpha;
    assign o_beta      = r_o_beta;
    assign o_conf      = r_o_conf;
    assign o_grid      = r_o_grid;
    assign o_ovf       = r_o_ovf;
    assign o_last      = r_o_last;

endmodule

[hdl/rsqf_ctrl.sv]
// controller: sequences divides, multiply jobs and result pushes for one request
module rsqf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rsqf_pkg::t_dp_stat   i_stat,
    output rsqf_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIVN, S_CONF, S_DIVC, S_MUL, S_DIVQ, S_FIN
    } t_state;

    t_state          r_state;
    rsqf_pkg::t_job  r_job;
    logic [1:0]      r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= rsqf_pkg::JOB_Q;
            r_phase <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_stat.first || i_stat.drop || i_stat.empty) r_state <= S_IDLE;
                    else r_state <= S_DIVN;
                end
                S_DIVN: begin
                    if (i_stat.div_done) r_state <= S_CONF;
                end
                S_CONF: begin
                    if (i_stat.conf_full) begin
                        r_state <= S_MUL;
                        r_job   <= rsqf_pkg::JOB_Q;
                        r_phase <= 2'd0;
                    end else begin
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (i_stat.div_done) begin
                        r_state <= S_MUL;
                        r_job   <= rsqf_pkg::JOB_Q;
                        r_phase <= 2'd0;
                    end
                end
                S_MUL: begin
                    if (r_phase != 2'd3) begin
                        r_phase <= r_phase + 2'd1;
                    end else if (r_job == rsqf_pkg::JOB_Q) begin
                        r_state <= S_DIVQ;
                    end else if (r_job == rsqf_pkg::JOB_BB) begin
                        if (!i_stat.out_full) begin
                            r_phase <= 2'd0;
                            r_job   <= rsqf_pkg::JOB_Q;
                            if (i_stat.last_pt) r_state <= S_FIN;
                        end
                    end else begin
                        r_phase <= 2'd0;
                        r_job   <= rsqf_pkg::t_job'(r_job + 3'd1);
                    end
                end
                S_DIVQ: begin
                    if (i_stat.div_done) begin
                        r_state <= S_MUL;
                        r_job   <= rsqf_pkg::JOB_U;
                        r_phase <= 2'd0;
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.job     = r_job;
        o_cmd.phase   = r_phase;
        o_cmd.div_sel = rsqf_pkg::DSEL_N;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_CHECK: begin
                if (i_stat.first) begin
                    o_cmd.store_first = 1'b1;
                end else if (i_stat.drop) begin
                    o_cmd.store_first = 1'b0;
                end else if (i_stat.empty) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_DIVN: begin
                o_cmd.latch_n = i_stat.div_done;
            end
            S_CONF: begin
                if (i_stat.conf_full) begin
                    o_cmd.set_conf_full = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rsqf_pkg::DSEL_CONF;
                end
            end
            S_DIVC: begin
                o_cmd.latch_conf = i_stat.div_done;
            end
            S_MUL: begin
                case (r_phase)
                    2'd0, 2'd1: o_cmd.mul_en = 1'b1;
                    2'd3: begin
                        if (r_job == rsqf_pkg::JOB_Q) begin
                            o_cmd.fin_job   = 1'b1;
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = rsqf_pkg::DSEL_Q;
                        end else if (r_job == rsqf_pkg::JOB_BB) begin
                            o_cmd.fin_job = ~i_stat.out_full;
                            o_cmd.push    = ~i_stat.out_full;
                        end else begin
                            o_cmd.fin_job = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.mul_en = 1'b0;
                    end
                endcase
            end
            S_DIVQ: begin
                o_cmd.div_sel  = rsqf_pkg::DSEL_Q;
                o_cmd.latch_ip = i_stat.div_done;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
